[src/divtmr_pkg.sv]
// shared types, codes and constants for the divider and interval timer
`timescale 1ns / 1ps
`default_nettype none
package divtmr_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam logic [7:0] UNMAPPED_DATA = 8'hFF;
  localparam int unsigned ENABLE_BIT   = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic tick_en;
    logic expire;
    logic out_busy;
  } status_t;

  function automatic logic [11:0] period_of(input logic [1:0] sel);
    logic [11:0] per;
    case (sel)
      2'd1:    per = 12'd16;
      2'd2:    per = 12'd64;
      2'd3:    per = 12'd256;
      default: per = 12'd1024;
    endcase
    return per;
  endfunction

endpackage
`default_nettype wire

[src/divtmr_ctrl.sv]
// controller state machine for the divider and interval timer
`timescale 1ns / 1ps
`default_nettype none
module divtmr_ctrl
  import divtmr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output logic         in_ready,
  output cmd_t         cmd,
  output state_t       state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.tick_en ? S_LOOP : S_DONE;
        end
      end
      S_LOOP: begin
        if (status.expire) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/divtmr_dp.sv]
// datapath: timer registers, prescalers, expiry step and output register
`timescale 1ns / 1ps
`default_nettype none
module divtmr_dp
  import divtmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  cycles,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic        out_ready,
  output status_t          status,
  output logic             out_valid,
  output logic [7:0]       read_data,
  output logic             timer_interrupt
);

  logic [7:0]  divider_value;
  logic [7:0]  divider_prescale;
  logic [7:0]  timer_count;
  logic [7:0]  timer_modulo;
  logic [7:0]  timer_control;
  logic [10:0] timer_prescale;
  logic [11:0] work_p;
  logic        work_irq;
  logic [7:0]  work_rd;

  logic [8:0]  div_sum;
  logic [11:0] per;
  logic [7:0]  rd_mux;

  assign div_sum = {1'b0, divider_prescale} + {1'b0, cycles};
  assign per     = period_of(timer_control[1:0]);

  always_comb begin
    case (address)
      ADDR_DIV:  rd_mux = divider_value;
      ADDR_TIMA: rd_mux = timer_count;
      ADDR_TMA:  rd_mux = timer_modulo;
      ADDR_TAC:  rd_mux = timer_control;
      default:   rd_mux = UNMAPPED_DATA;
    endcase
  end

  assign status.tick_en  = (mode == MODE_TICK) && timer_control[ENABLE_BIT];
  assign status.expire   = work_p >= per;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_value    <= '0;
      divider_prescale <= '0;
      timer_count      <= '0;
      timer_modulo     <= '0;
      timer_control    <= '0;
      timer_prescale   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        work_irq <= 1'b0;
        work_rd  <= '0;
        work_p   <= {1'b0, timer_prescale} + {4'b0, cycles};
        case (mode)
          MODE_TICK: begin
            divider_prescale <= div_sum[7:0];
            if (div_sum[8]) begin
              divider_value <= divider_value + 8'd1;
            end
          end
          MODE_WRITE: begin
            case (address)
              ADDR_DIV: begin
                divider_value    <= '0;
                divider_prescale <= '0;
              end
              ADDR_TIMA: timer_count   <= write_data;
              ADDR_TMA:  timer_modulo  <= write_data;
              ADDR_TAC:  timer_control <= write_data;
              default: ;
            endcase
          end
          MODE_READ: begin
            work_rd <= rd_mux;
          end
          default: ;
        endcase
      end
      if (cmd.step) begin
        work_p <= work_p - per;
        if (timer_count == 8'hFF) begin
          timer_count <= timer_modulo;
          work_irq    <= 1'b1;
        end else begin
          timer_count <= timer_count + 8'd1;
        end
      end
      if (cmd.finish) begin
        timer_prescale <= work_p[10:0];
      end
      if (cmd.publish) begin
        out_valid       <= 1'b1;
        read_data       <= work_rd;
        timer_interrupt <= work_irq;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/divider_and_interval_timer.sv]
// top level of the divider and interval timer
`timescale 1ns / 1ps
`default_nettype none
// Each input word is a tick of elapsed machine cycles, a bus write or a bus read, and
// gives exactly one output word. Reads, writes, unused modes and ticks with the timer
// disabled go from acceptance straight to the done state, then to the output register.
// An enabled tick first handles its n timer prescaler expiries in the loop state: the
// shared subtract-and-count step handles one expiry per cycle (n is 0 to 16 in steady
// use, up to 79 after a control write shortens the period). A new word is accepted
// while the previous output word still waits to be taken.
module divider_and_interval_timer
  import divtmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  cycles,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             timer_interrupt
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  divtmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  divtmr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mode            (mode),
    .cycles          (cycles),
    .address         (address),
    .write_data      (write_data),
    .out_ready       (out_ready),
    .status          (status),
    .out_valid       (out_valid),
    .read_data       (read_data),
    .timer_interrupt (timer_interrupt)
  );

  a_direct_done : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode != MODE_TICK) |=> (state == S_DONE))
    else $error("non-tick word did not go straight to done");

  a_loop_blocks : assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> !in_ready)
    else $error("input accepted during expiry loop");

  a_publish_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("output word raised outside done state");

  a_held_output : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == S_DONE) |=> (state == S_DONE))
    else $error("done state left while output register full");

endmodule
`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the divider and interval timer, directed and random bus words
`timescale 1ns / 1ps
module tb;
  import divtmr_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_PRINTED  = 40;

  typedef struct packed {
    logic        hold;
    logic [1:0]  mode;
    logic [7:0]  cycles;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_interrupt;
  } timer_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_TOGGLE,
    READY_SPARSE
  } ready_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_TICK;
  logic [7:0]  cycles = '0;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        timer_interrupt;

  bus_word_t     pending_words[$];
  timer_result_t expected_results[$];
  bus_word_t     next_word;
  timer_result_t oldest_result;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned results_seen = 0;

  // predicted register file
  logic [7:0]  div_reg = '0;
  logic [7:0]  div_pre = '0;
  logic [7:0]  tima_reg = '0;
  logic [7:0]  tma_reg = '0;
  logic [7:0]  tac_reg = '0;
  logic [10:0] timer_pre = '0;

  divider_and_interval_timer dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned timer_period(input logic [1:0] sel);
    int unsigned per;
    case (sel)
      SEL_16:  per = 16;
      SEL_64:  per = 64;
      SEL_256: per = 256;
      default: per = 1024;
    endcase
    return per;
  endfunction

  function automatic timer_result_t advance_timer(input bus_word_t w);
    timer_result_t res;
    int unsigned acc;
    int unsigned per;
    res = '0;
    case (w.mode)
      MODE_TICK: begin
        acc = div_pre + w.cycles;
        if (acc >= 256) begin
          div_reg = div_reg + 8'd1;
          acc = acc - 256;
        end
        div_pre = acc[7:0];
        if (tac_reg[ENABLE_BIT]) begin
          acc = timer_pre + w.cycles;
          per = timer_period(tac_reg[1:0]);
          while (acc >= per) begin
            acc = acc - per;
            if (tima_reg == 8'hFF) begin
              tima_reg = tma_reg;
              res.timer_interrupt = 1'b1;
            end else begin
              tima_reg = tima_reg + 8'd1;
            end
          end
          timer_pre = acc[10:0];
        end
      end
      MODE_WRITE: begin
        case (w.address)
          ADDR_DIV: begin
            div_reg = '0;
            div_pre = '0;
          end
          ADDR_TIMA: tima_reg = w.write_data;
          ADDR_TMA:  tma_reg = w.write_data;
          ADDR_TAC:  tac_reg = w.write_data;
          default: ;
        endcase
      end
      MODE_READ: begin
        case (w.address)
          ADDR_DIV:  res.read_data = div_reg;
          ADDR_TIMA: res.read_data = tima_reg;
          ADDR_TMA:  res.read_data = tma_reg;
          ADDR_TAC:  res.read_data = tac_reg;
          default:   res.read_data = UNMAPPED_DATA;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic push_word(input logic hold, input logic [1:0] m, input logic [7:0] c,
                           input logic [15:0] a, input logic [7:0] d);
    bus_word_t w;
    w.hold = hold;
    w.mode = m;
    w.cycles = c;
    w.address = a;
    w.write_data = d;
    pending_words.push_back(w);
  endtask

  task automatic push_tick(input logic [7:0] c);
    push_word(1'b0, MODE_TICK, c, 16'($urandom), 8'($urandom));
  endtask

  task automatic push_write(input logic [15:0] a, input logic [7:0] d);
    push_word(1'b0, MODE_WRITE, 8'($urandom), a, d);
  endtask

  task automatic push_read(input logic [15:0] a);
    push_word(1'b0, MODE_READ, 8'($urandom), a, 8'($urandom));
  endtask

  task automatic push_spare();
    push_word(1'b0, MODE_SPARE, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] pick_register();
    logic [15:0] a;
    case ($urandom_range(0, 5))
      0:       a = ADDR_DIV;
      1:       a = ADDR_TIMA;
      2:       a = ADDR_TMA;
      default: a = ADDR_TAC;
    endcase
    return a;
  endfunction

  task automatic push_random_word();
    int unsigned pick;
    int unsigned sel;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (pick < 55) begin
      if (sel == 0) begin
        push_tick(8'd0);
      end else if (sel == 1) begin
        push_tick(8'd255);
      end else begin
        push_tick(8'($urandom));
      end
    end else if (pick < 77) begin
      addr = (sel < 8) ? pick_register() : 16'($urandom);
      data = 8'($urandom);
      if (addr == ADDR_TAC && $urandom_range(0, 4) != 0) data[ENABLE_BIT] = 1'b1;
      if (addr == ADDR_TIMA && $urandom_range(0, 2) == 0) data[7:4] = 4'hF;
      push_write(addr, data);
    end else if (pick < 95) begin
      push_read((sel < 8) ? pick_register() : 16'($urandom));
    end else begin
      push_spare();
    end
  endtask

  // sender: bursts of words separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   (!pending_words[0].hold || (!in_valid && expected_results.size() == 0))) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        mode <= next_word.mode;
        cycles <= next_word.cycles;
        address <= next_word.address;
        write_data <= next_word.write_data;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches among four random styles
  ready_style_t ready_style = READY_ALWAYS;
  int unsigned  style_left = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 120);
    end else begin
      style_left = style_left - 1;
    end
    case (ready_style)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_TOGGLE: out_ready <= ~out_ready;
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: predict on each accepted word, check each taken word
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("word %0d: read_data=%02h timer_interrupt=%0b not expected",
                                    results_seen, read_data, timer_interrupt));
        end else begin
          oldest_result = expected_results.pop_front();
          if (read_data !== oldest_result.read_data)
            report_mismatch($sformatf("word %0d: read_data %02h, want %02h",
                                      results_seen, read_data, oldest_result.read_data));
          if (timer_interrupt !== oldest_result.timer_interrupt)
            report_mismatch($sformatf("word %0d: timer_interrupt %0b, want %0b", results_seen,
                                      timer_interrupt, oldest_result.timer_interrupt));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(advance_timer({1'b0, mode, cycles, address, write_data}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    push_read(ADDR_DIV);
    push_read(ADDR_TAC);
    push_read(16'hFF0F);
    push_read(16'h0000);
    push_read(16'hFF08);
    push_spare();
    push_write(ADDR_TMA, 8'hFF);
    push_write(ADDR_TIMA, 8'hFE);
    push_write(ADDR_TAC, 8'hFC);
    repeat (4) push_tick(8'd255);
    // shorten the period below the prescaler so the next tick expires many times
    push_write(ADDR_TAC, 8'h05);
    push_tick(8'd255);
    push_read(ADDR_TIMA);
    push_read(ADDR_DIV);
    push_write(ADDR_DIV, 8'h5A);
    push_read(ADDR_DIV);
    push_write(16'hFF03, 8'h00);
    push_write(ADDR_TAC, 8'h06);
    push_tick(8'd0);
    push_write(ADDR_TAC, 8'h07);
    push_tick(8'd255);
    push_write(ADDR_TAC, 8'h03);
    push_tick(8'd200);
    push_read(ADDR_TAC);
    push_read(ADDR_TMA);
    push_write(ADDR_TIMA, 8'h00);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 200 == 100) begin
        push_word(1'b1, MODE_READ, 8'($urandom), ADDR_TIMA, 8'($urandom));
      end else begin
        push_random_word();
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_results.size()));

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/divtmr_pkg.sv
src/divtmr_ctrl.sv
src/divtmr_dp.sv
src/divider_and_interval_timer.sv
tb/tb.sv
